// ----- sv/insertion_sorter_unit_assert.svh -----
// Assertion macros for the insertion sorter unit.
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/iss_pkg.sv -----
// Types and constants shared by the insertion sorter modules.
package iss_pkg;

   localparam int CAPACITY = 64;

   typedef struct packed {
      logic signed [31:0] value;
      logic               set_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               run_end;
      logic               overflowed;
   } rsp_type;

   typedef struct packed {
      logic               insert;
      logic               shift;
      logic signed [31:0] value;
   } cell_ctrl_type;

endpackage

// ----- sv/iss_cell.sv -----
// One cell of the sorter chain: holds one value, inserts or shifts toward the head.
module iss_cell
   import iss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic signed [31:0] left_value,
   input  logic               left_valid,
   input  logic               left_gt,
   input  logic signed [31:0] right_value,
   input  logic               right_valid,
   output logic signed [31:0] value,
   output logic               valid,
   output logic               gt
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;

   // empty cells count as larger than anything; equal values stay ahead
   assign gt = !valid_ff || (value_ff > ctrl.value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.insert && gt) begin
         if (!left_gt) begin
            value_in = ctrl.value;
            valid_in = 1'b1;
         end else begin
            value_in = left_value;
            valid_in = left_valid;
         end
      end else if (ctrl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ----- sv/insertion_sorter_unit.sv -----
// Insertion sorter unit: a chain of CAPACITY cells keeps each set in stable ascending order.
// Loading takes one request per cycle: each value is compared against every cell at once
// and the larger cells move one place down the chain. A request with set_end is inserted,
// then the chain drains from its head, one result per cycle while rsp_stall is low;
// req_stall stays high for the whole drain. At most CAPACITY
// values are kept; later values of the set are dropped and overflowed is set on its results.
`include "insertion_sorter_unit_assert.svh"

module insertion_sorter_unit
   import iss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                draining_ff, draining_in;
   logic                dropped_ff, dropped_in;
   cell_ctrl_type       ctrl;
   logic signed [31:0]  cell_value [CAPACITY];
   logic [CAPACITY-1:0] cell_valid;
   logic [CAPACITY-1:0] cell_gt;
   logic                req_take, rsp_take, full;

   assign req_stall = draining_ff;
   assign req_take  = req_valid && !draining_ff;
   assign full      = cell_valid[CAPACITY-1];

   assign rsp_valid             = draining_ff && cell_valid[0];
   assign rsp_take              = rsp_valid && !rsp_stall;
   assign rsp_data.sorted_value = cell_value[0];
   assign rsp_data.run_end      = !cell_valid[1];
   assign rsp_data.overflowed   = dropped_ff;

   assign ctrl.insert = req_take && !full;
   assign ctrl.shift  = rsp_take;
   assign ctrl.value  = req_data.value;

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (req_take) begin
         if (full) begin
            dropped_in = 1'b1;
         end
         if (req_data.set_end) begin
            draining_in = 1'b1;
         end
      end else if (rsp_take && rsp_data.run_end) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] l_value, r_value;
      logic               l_valid, l_gt, r_valid;

      if (i == 0) begin : g_head
         assign l_value = req_data.value;
         assign l_valid = 1'b0;
         assign l_gt    = 1'b0;
      end else begin : g_body
         assign l_value = cell_value[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_value = cell_value[i];
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_value = cell_value[i+1];
         assign r_valid = cell_valid[i+1];
      end

      iss_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_value  (l_value),
         .left_valid  (l_valid),
         .left_gt     (l_gt),
         .right_value (r_value),
         .right_valid (r_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   `ISU_ASSERT_NEXT(a_drain_starts, req_take && req_data.set_end, rsp_valid,
      "set end did not start a drain")
   `ISU_ASSERT_NEXT(a_drain_empties, rsp_take && rsp_data.run_end,
      cell_valid == '0 && !draining_ff && !dropped_ff, "chain not empty after run end")
   `ISU_ASSERT_NOW(a_cells_packed, 1'b1, (cell_valid & (cell_valid + CAPACITY'(1))) == '0,
      "occupied cells not packed at the head")

endmodule
